// ----- design/u8d_pkg.sv -----
// shared types and constants of the utf-8 to utf-32 decoder
package u8d_pkg;

	localparam int CP_W        = 21;
	localparam int SRC_OFF_W   = 32;
	localparam int MAX_RESULTS = 4;

	localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

	// byte class tags, compared against the top bits of a byte
	localparam logic [1:0] CONT_TAG  = 2'b10;
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;
	localparam logic [5:0] PAYLOAD6  = 6'b11_1111;

	typedef enum logic [2:0] {
		SEQ_NONE  = 3'd0,
		SEQ_TWO   = 3'd2,
		SEQ_THREE = 3'd3,
		SEQ_FOUR  = 3'd4
	} seq_len_t;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] cnt;
		seq_len_t   need;
	} dec_state_t;

	typedef struct packed {
		logic [CP_W-1:0]      code_point;
		logic [SRC_OFF_W-1:0] source_offset;
		logic                 run_last;
		logic                 text_done;
	} result_t;

endpackage

// ----- design/u8d_in_if.sv -----
// byte channel of the decoder
interface u8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       text_end;

	modport source (output valid, output in_byte, output text_end, input ready);
	modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

// ----- design/u8d_out_if.sv -----
// code point channel of the decoder
interface u8d_out_if;
	logic                           valid;
	logic                           ready;
	logic [u8d_pkg::CP_W-1:0]      code_point;
	logic [u8d_pkg::SRC_OFF_W-1:0] source_offset;
	logic                           run_last;
	logic                           text_done;

	modport source (output valid, output code_point, output source_offset,
		output run_last, output text_done, input ready);
	modport sink (input valid, input code_point, input source_offset,
		input run_last, input text_done, output ready);
endinterface

// ----- design/u8d_decode.sv -----
// one byte step: next decoder state and the list of results it causes
module u8d_decode #(
	parameter int OFFSET_WIDTH = 32
) (
	input  u8d_pkg::dec_state_t      st,
	input  logic [OFFSET_WIDTH-1:0] pos,
	input  logic [7:0]              in_byte,
	input  logic                    text_end,
	output u8d_pkg::dec_state_t      st_nxt,
	output logic [OFFSET_WIDTH-1:0] pos_nxt,
	output u8d_pkg::result_t         res [u8d_pkg::MAX_RESULTS],
	output logic [2:0]              n
);

	logic [u8d_pkg::CP_W-1:0] cp_l   [u8d_pkg::MAX_RESULTS];
	logic [1:0]               back_l [u8d_pkg::MAX_RESULTS];
	logic [u8d_pkg::CP_W-1:0] cp_done;
	logic [OFFSET_WIDTH-1:0]  offs   [u8d_pkg::MAX_RESULTS];
	logic                     pending;
	logic                     is_cont;
	logic                     completes;
	logic                     do_start;
	logic [2:0]               idx;

	assign pending   = (st.need != u8d_pkg::SEQ_NONE) && (st.cnt != 2'd0);
	assign is_cont   = (in_byte[7:6] == u8d_pkg::CONT_TAG);
	assign completes = ({1'b0, st.cnt} + 3'd1) == 3'(st.need);

	always_comb begin
		case (st.need)
			u8d_pkg::SEQ_TWO:   cp_done = {10'b0, st.b0[4:0], in_byte[5:0] & u8d_pkg::PAYLOAD6};
			u8d_pkg::SEQ_THREE: cp_done = {5'b0, st.b0[3:0], st.b1[5:0],
				in_byte[5:0] & u8d_pkg::PAYLOAD6};
			u8d_pkg::SEQ_FOUR:  cp_done = {st.b0[2:0], st.b1[5:0], st.b2[5:0],
				in_byte[5:0] & u8d_pkg::PAYLOAD6};
			default:            cp_done = '0;
		endcase
	end

	always_comb begin
		st_nxt   = st;
		n        = 3'd0;
		do_start = 1'b0;
		idx      = 3'd0;
		for (int k = 0; k < u8d_pkg::MAX_RESULTS; k++) begin
			cp_l[k]   = '0;
			back_l[k] = 2'd0;
		end

		if (!pending) begin
			do_start = 1'b1;
		end else if (is_cont && completes) begin
			cp_l[0]     = cp_done;
			back_l[0]   = st.cnt;
			n           = 3'd1;
			st_nxt.cnt  = 2'd0;
			st_nxt.need = u8d_pkg::SEQ_NONE;
		end else if (is_cont && st.cnt != 2'd3) begin
			if (st.cnt == 2'd1) begin
				st_nxt.b1 = in_byte;
			end else begin
				st_nxt.b2 = in_byte;
			end
			st_nxt.cnt = st.cnt + 2'd1;
		end else begin
			// broken sequence: every held byte becomes a replacement
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < st.cnt) begin
					cp_l[k]   = u8d_pkg::REPLACEMENT;
					back_l[k] = st.cnt - 2'(k);
				end
			end
			n        = {1'b0, st.cnt};
			do_start = 1'b1;
		end

		if (do_start) begin
			st_nxt.cnt  = 2'd0;
			st_nxt.need = u8d_pkg::SEQ_NONE;
			if (in_byte[7] == 1'b0) begin
				cp_l[n[1:0]]   = {13'b0, in_byte};
				back_l[n[1:0]] = 2'd0;
				n              = n + 3'd1;
			end else if (in_byte[7:5] == u8d_pkg::LEAD2_TAG) begin
				st_nxt.b0   = in_byte;
				st_nxt.cnt  = 2'd1;
				st_nxt.need = u8d_pkg::SEQ_TWO;
			end else if (in_byte[7:4] == u8d_pkg::LEAD3_TAG) begin
				st_nxt.b0   = in_byte;
				st_nxt.cnt  = 2'd1;
				st_nxt.need = u8d_pkg::SEQ_THREE;
			end else if (in_byte[7:3] == u8d_pkg::LEAD4_TAG) begin
				st_nxt.b0   = in_byte;
				st_nxt.cnt  = 2'd1;
				st_nxt.need = u8d_pkg::SEQ_FOUR;
			end else begin
				cp_l[n[1:0]]   = u8d_pkg::REPLACEMENT;
				back_l[n[1:0]] = 2'd0;
				n              = n + 3'd1;
			end
		end

		if (text_end) begin
			// cut-off sequence: flush what is still held, offsets counted back from the current byte
			if (st_nxt.need != u8d_pkg::SEQ_NONE) begin
				for (int k = 0; k < 3; k++) begin
					idx = n + 3'(k);
					if (2'(k) < st_nxt.cnt && idx < 3'(u8d_pkg::MAX_RESULTS)) begin
						cp_l[idx[1:0]]   = u8d_pkg::REPLACEMENT;
						back_l[idx[1:0]] = st_nxt.cnt - 2'd1 - 2'(k);
					end
				end
				n = n + {1'b0, st_nxt.cnt};
			end
			st_nxt.cnt  = 2'd0;
			st_nxt.need = u8d_pkg::SEQ_NONE;
		end
	end

	assign pos_nxt = text_end ? '0 : pos + OFFSET_WIDTH'(1);

	for (genvar g = 0; g < u8d_pkg::MAX_RESULTS; g++) begin : g_res
		assign offs[g]              = pos - OFFSET_WIDTH'(back_l[g]);
		assign res[g].code_point    = cp_l[g];
		assign res[g].source_offset = u8d_pkg::SRC_OFF_W'(offs[g]);
		assign res[g].run_last      = (3'(g) + 3'd1) == n;
		assign res[g].text_done     = ((3'(g) + 3'd1) == n) && text_end;
	end

endmodule

// ----- design/u8d_resq.sv -----
// result register: holds the results of one byte and drains them one per transfer
module u8d_resq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  u8d_pkg::result_t ents [u8d_pkg::MAX_RESULTS],
	input  logic [2:0]       n,
	output logic             free,
	u8d_out_if.source        utf32
);

	u8d_pkg::result_t ent_q [u8d_pkg::MAX_RESULTS];
	logic [1:0]       rd_q;
	logic [2:0]       left_q;
	logic             pop;

	assign pop  = utf32.valid && utf32.ready;
	assign free = (left_q == 3'd0) || (left_q == 3'd1 && utf32.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= 2'd0;
			left_q <= 3'd0;
		end else if (load && n != 3'd0) begin
			rd_q   <= 2'd0;
			left_q <= n;
		end else if (pop) begin
			rd_q   <= rd_q + 2'd1;
			left_q <= left_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && n != 3'd0) begin
			ent_q <= ents;
		end
	end

	assign utf32.valid         = (left_q != 3'd0);
	assign utf32.code_point    = ent_q[rd_q].code_point;
	assign utf32.source_offset = ent_q[rd_q].source_offset;
	assign utf32.run_last      = ent_q[rd_q].run_last;
	assign utf32.text_done     = ent_q[rd_q].text_done;

endmodule

// ----- design/utf8_to_utf32_decoder_core.sv -----
// Streaming UTF-8 to UTF-32 decoder. Bytes enter on utf8, one per transfer, with text_end on
// the last byte of a text; code points leave on utf32 tagged with the offset of their first
// byte. Invalid bytes and broken or cut-off sequences give U+FFFD, one per byte involved.
// A byte is registered, decoded against the held sequence and its results (zero to four)
// are loaded into the result register, from which they leave on utf32. One byte is accepted
// per cycle as long as each byte gives at most one result and utf32 is not stalled; a byte
// that gives several results occupies the single output port for one transfer each, which
// holds input back until its last result is taken. Offsets wrap at 2^OFFSET_WIDTH and restart
// at zero after text_end.
module utf8_to_utf32_decoder_core #(
	parameter int OFFSET_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	u8d_in_if.sink    utf8,
	u8d_out_if.source utf32
);

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    end_s1;
	u8d_pkg::dec_state_t     state_q;
	u8d_pkg::dec_state_t     state_nxt;
	logic [OFFSET_WIDTH-1:0] pos_q;
	logic [OFFSET_WIDTH-1:0] pos_nxt;
	u8d_pkg::result_t        res [u8d_pkg::MAX_RESULTS];
	logic [2:0]              res_n;
	logic                    q_free;
	logic                    adv;

	assign adv        = valid_s1 && q_free;
	assign utf8.ready = !valid_s1 || q_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (utf8.valid && utf8.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (utf8.valid && utf8.ready) begin
			byte_s1 <= utf8.in_byte;
			end_s1  <= utf8.text_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{b0: 8'd0, b1: 8'd0, b2: 8'd0, cnt: 2'd0, need: u8d_pkg::SEQ_NONE};
			pos_q   <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
			pos_q   <= pos_nxt;
		end
	end

	u8d_decode #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_decode (
		.st      (state_q),
		.pos     (pos_q),
		.in_byte (byte_s1),
		.text_end(end_s1),
		.st_nxt  (state_nxt),
		.pos_nxt (pos_nxt),
		.res     (res),
		.n       (res_n)
	);

	u8d_resq u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (adv),
		.ents  (res),
		.n     (res_n),
		.free  (q_free),
		.utf32 (utf32)
	);

endmodule

// ----- design/u8d_checker.sv -----
// port-level checks of the decoder, bound to the top level
module u8d_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [u8d_pkg::CP_W-1:0]      code_point,
	input logic [u8d_pkg::SRC_OFF_W-1:0] source_offset,
	input logic                           run_last,
	input logic                           text_done
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_point)
			&& $stable(source_offset) && $stable(run_last) && $stable(text_done))
		else $error("result changed while stalled");

	// end of text is only flagged on the last result of its byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_done |-> run_last)
		else $error("text_done without run_last");

	// input is only held back while results wait
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// the rest of one byte's results follow without a gap
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("gap inside the results of one byte");

endmodule

bind utf8_to_utf32_decoder_core u8d_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (utf8.ready),
	.out_valid    (utf32.valid),
	.out_ready    (utf32.ready),
	.code_point   (utf32.code_point),
	.source_offset(utf32.source_offset),
	.run_last     (utf32.run_last),
	.text_done    (utf32.text_done)
);
